// File: rtl/core/sorted_slot_page_table_top_defines.svh
// ----------------------------------------------------------------------------
// Sorted slot page table: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_SLOT_PAGE_TABLE_TOP_DEFINES_SVH
`define SORTED_SLOT_PAGE_TABLE_TOP_DEFINES_SVH

// property holds at every edge out of reset
`define SSP_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted slot page table: shared package
// Command and status codes, fixed field widths and the sequencer states.
// ----------------------------------------------------------------------------
package ssp_pkg;

   localparam int CMD_BITS    = 3;
   localparam int SLOT_BITS   = 8;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 7;

   localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_READ   = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_NEXT   = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_PREV   = 3'd4;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd3;

   localparam logic [SLOT_BITS-1:0] SLOT_NONE = 8'hFF;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_SCAN    = 9'b000000010,
      S_MOVE_RD = 9'b000000100,
      S_MOVE_WR = 9'b000001000,
      S_PLACE   = 9'b000010000,
      S_CHECK   = 9'b000100000,
      S_WALK    = 9'b001000000,
      S_LOOK    = 9'b010000000,
      S_EMIT    = 9'b100000000
   } state_type;

endpackage

// File: rtl/core/ssp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted slot page table: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ssp_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted slot page table: shared step unit
// Steps the slot position by one in either direction and compares two keys.
// ----------------------------------------------------------------------------
module ssp_alu import ssp_pkg::*; #(
   parameter int POS_BITS = 9,
   parameter int KEY_BITS = 32
) (
   input  logic signed [POS_BITS-1:0] pos,
   input  logic                       dec,
   input  logic        [KEY_BITS-1:0] key_a,
   input  logic        [KEY_BITS-1:0] key_b,
   output logic signed [POS_BITS-1:0] pos_next,
   output logic                       key_le
);

   always_comb begin
      pos_next = dec ? (pos - POS_BITS'(1)) : (pos + POS_BITS'(1));
      key_le   = $signed(key_a) <= $signed(key_b);
   end

endmodule

// File: rtl/core/sorted_slot_page_table_top.sv
`timescale 1ns / 1ps
// Steps: insert scans every slot, moves entries by a read and a write each, ends the
// moves, places; delete checks; read checks, next/previous walk, then look up; all emit.
// Throughput: one beat at a time; the shared RAM read address and single step unit set the pace.
// The result register frees the input side while a result beat waits.
// Reset: used bitmap, entry count, response valid and sequencer clear; store contents
// stay undefined until written.
// ----------------------------------------------------------------------------
// Sorted slot page table: top level
// Page of slots kept in signed key order with insert, delete, read and scans.
// ----------------------------------------------------------------------------
`include "sorted_slot_page_table_top_defines.svh"

module sorted_slot_page_table_top import ssp_pkg::*; #(
   parameter int SLOTS        = 64,
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   // tdata: key, payload, slot
   input  logic [((KEY_BITS+PAYLOAD_BITS+SLOT_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: cmd
   input  logic [CMD_BITS-1:0]                                  req_tuser,
   input  logic                                                 req_tvalid,
   output logic                                                 req_tready,
   // tdata: result_slot, slot_used, out_key, out_payload, entry_count
   output logic [((SLOT_BITS+1+KEY_BITS+PAYLOAD_BITS+COUNT_BITS+7)/8)*8-1:0] rsp_tdata,
   // tuser: status
   output logic [STATUS_BITS-1:0]                               rsp_tuser,
   output logic                                                 rsp_tvalid,
   input  logic                                                 rsp_tready
);

   localparam int RSP_F = SLOT_BITS+1+KEY_BITS+PAYLOAD_BITS+COUNT_BITS;
   localparam int RSP_W = ((RSP_F+7)/8)*8;
   localparam int IW    = $clog2(SLOTS);
   localparam int PW    = (IW+2 > SLOT_BITS+1) ? IW+2 : SLOT_BITS+1;
   localparam int CW    = $clog2(SLOTS+1);
   localparam logic signed [PW-1:0] SLOTS_P = PW'(SLOTS);
   localparam logic signed [PW-1:0] NONE_P  = '1;

   state_type                state_ff, state_in;
   logic [CMD_BITS-1:0]      cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [PAYLOAD_BITS-1:0]  pay_ff, pay_in;
   logic [SLOT_BITS-1:0]     slot_ff, slot_in;
   logic signed [PW-1:0]     pos_ff, pos_in;
   logic signed [PW-1:0]     hole_ff, hole_in;
   logic                     hole_found_ff, hole_found_in;
   logic signed [PW-1:0]     le_ff, le_in;
   logic                     le_act_ff, le_act_in;
   logic                     dec_ff, dec_in;
   logic [IW-1:0]            src_ff, src_in;
   logic [IW-1:0]            rd_idx_ff, rd_idx_in;
   logic                     pend_ff, pend_in;
   logic [SLOTS-1:0]         used_ff, used_in;
   logic [CW-1:0]            count_ff, count_in;

   logic [STATUS_BITS-1:0]   res_status_ff, res_status_in;
   logic [SLOT_BITS-1:0]     res_slot_ff, res_slot_in;
   logic                     res_used_ff, res_used_in;
   logic [KEY_BITS-1:0]      res_key_ff, res_key_in;
   logic [PAYLOAD_BITS-1:0]  res_pay_ff, res_pay_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [RSP_F-1:0]         rsp_data_ff, rsp_data_in;

   logic                     ram_we;
   logic [IW-1:0]            ram_waddr;
   logic [IW-1:0]            ram_raddr;
   logic [KEY_BITS-1:0]      ram_wkey, ram_rkey;
   logic [PAYLOAD_BITS-1:0]  ram_wpay, ram_rpay;

   logic signed [PW-1:0]     alu_next;
   logic                     alu_le;
   logic                     req_beat;
   logic                     rsp_load;
   logic signed [PW-1:0]     req_slot_s;
   logic signed [PW-1:0]     slot_s;
   logic [IW-1:0]            pos_idx;
   logic [IW-1:0]            next_idx;

   ssp_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wkey),
      .rd_addr (ram_raddr),
      .rd_data (ram_rkey)
   );

   ssp_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_pay_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wpay),
      .rd_addr (ram_raddr),
      .rd_data (ram_rpay)
   );

   ssp_alu #(.POS_BITS(PW), .KEY_BITS(KEY_BITS)) u_alu (
      .pos      (pos_ff),
      .dec      (dec_ff),
      .key_a    (ram_rkey),
      .key_b    (key_ff),
      .pos_next (alu_next),
      .key_le   (alu_le)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign req_slot_s = $signed({{(PW-SLOT_BITS){req_tdata[KEY_BITS+PAYLOAD_BITS+SLOT_BITS-1]}},
                                req_tdata[KEY_BITS+PAYLOAD_BITS +: SLOT_BITS]});
   assign slot_s     = $signed({{(PW-SLOT_BITS){slot_ff[SLOT_BITS-1]}}, slot_ff});
   assign pos_idx    = pos_ff[IW-1:0];
   assign next_idx   = alu_next[IW-1:0];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      slot_in       = slot_ff;
      pos_in        = pos_ff;
      hole_in       = hole_ff;
      hole_found_in = hole_found_ff;
      le_in         = le_ff;
      le_act_in     = le_act_ff;
      dec_in        = dec_ff;
      src_in        = src_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = pend_ff;
      used_in       = used_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_used_in   = res_used_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      ram_we        = 1'b0;
      ram_waddr     = pos_idx;
      ram_raddr     = pos_idx;
      ram_wkey      = ram_rkey;
      ram_wpay      = ram_rpay;

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               cmd_in        = req_tuser;
               key_in        = req_tdata[KEY_BITS-1:0];
               pay_in        = req_tdata[KEY_BITS +: PAYLOAD_BITS];
               slot_in       = req_tdata[KEY_BITS+PAYLOAD_BITS +: SLOT_BITS];
               res_status_in = STATUS_OK;
               res_slot_in   = SLOT_NONE;
               res_used_in   = 1'b0;
               res_key_in    = '0;
               res_pay_in    = '0;
               case (req_tuser)
                  CMD_INSERT: begin
                     pos_in        = '0;
                     hole_found_in = 1'b0;
                     le_in         = NONE_P;
                     le_act_in     = 1'b1;
                     pend_in       = 1'b0;
                     dec_in        = 1'b0;
                     state_in      = S_SCAN;
                  end
                  CMD_DELETE, CMD_READ: begin
                     state_in = S_CHECK;
                  end
                  CMD_NEXT: begin
                     pos_in   = (req_slot_s < NONE_P) ? NONE_P : req_slot_s;
                     dec_in   = 1'b0;
                     state_in = S_WALK;
                  end
                  CMD_PREV: begin
                     pos_in   = (req_slot_s > SLOTS_P) ? SLOTS_P : req_slot_s;
                     dec_in   = 1'b1;
                     state_in = S_WALK;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end

         S_SCAN: begin
            ram_raddr = pos_idx;
            if (pos_ff < SLOTS_P) begin
               if (!used_ff[pos_idx] && !hole_found_ff) begin
                  hole_in       = pos_ff;
                  hole_found_in = 1'b1;
               end
               pos_in    = alu_next;
               rd_idx_in = pos_idx;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && le_act_ff && used_ff[rd_idx_ff]) begin
               if (alu_le) begin
                  le_in = $signed({{(PW-IW){1'b0}}, rd_idx_ff});
               end else begin
                  le_act_in = 1'b0;
               end
            end
            if ((pos_ff == SLOTS_P) && !pend_ff) begin
               if (!hole_found_ff) begin
                  res_status_in = STATUS_FULL;
                  state_in      = S_EMIT;
               end else begin
                  dec_in   = !(hole_ff < le_ff);
                  pos_in   = hole_ff;
                  state_in = S_MOVE_RD;
               end
            end
         end

         S_MOVE_RD: begin
            if (dec_ff ? (alu_next <= le_ff) : (pos_ff >= le_ff)) begin
               state_in = S_PLACE;
            end else begin
               ram_raddr = next_idx;
               src_in    = next_idx;
               state_in  = S_MOVE_WR;
            end
         end

         S_MOVE_WR: begin
            if (!used_ff[pos_idx] && used_ff[src_ff]) begin
               ram_we           = 1'b1;
               ram_waddr        = pos_idx;
               used_in[pos_idx] = 1'b1;
               used_in[src_ff]  = 1'b0;
            end
            pos_in   = alu_next;
            state_in = S_MOVE_RD;
         end

         S_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = pos_idx;
            ram_wkey  = key_ff;
            ram_wpay  = pay_ff;
            if (!used_ff[pos_idx]) begin
               count_in = count_ff + CW'(1);
            end
            used_in[pos_idx] = 1'b1;
            res_slot_in      = pos_ff[SLOT_BITS-1:0];
            res_used_in      = 1'b1;
            res_key_in       = key_ff;
            res_pay_in       = pay_ff;
            state_in         = S_EMIT;
         end

         S_CHECK: begin
            res_slot_in = slot_ff;
            ram_raddr   = slot_s[IW-1:0];
            if (slot_s[PW-1] || (slot_s >= SLOTS_P)) begin
               res_status_in = STATUS_RANGE;
               state_in      = S_EMIT;
            end else if (!used_ff[slot_s[IW-1:0]]) begin
               res_status_in = STATUS_EMPTY;
               state_in      = S_EMIT;
            end else if (cmd_ff == CMD_DELETE) begin
               used_in[slot_s[IW-1:0]] = 1'b0;
               count_in                = count_ff - CW'(1);
               state_in                = S_EMIT;
            end else begin
               res_used_in = 1'b1;
               state_in    = S_LOOK;
            end
         end

         S_WALK: begin
            ram_raddr = next_idx;
            if (!dec_ff && (alu_next >= SLOTS_P)) begin
               res_slot_in = SLOTS_P[SLOT_BITS-1:0];
               state_in    = S_EMIT;
            end else if (dec_ff && alu_next[PW-1]) begin
               res_slot_in = SLOT_NONE;
               state_in    = S_EMIT;
            end else if (used_ff[next_idx]) begin
               res_slot_in = alu_next[SLOT_BITS-1:0];
               res_used_in = 1'b1;
               state_in    = S_LOOK;
            end else begin
               pos_in = alu_next;
            end
         end

         S_LOOK: begin
            res_key_in = ram_rkey;
            res_pay_in = ram_rpay;
            state_in   = S_EMIT;
         end

         S_EMIT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_data_in   = {COUNT_BITS'(count_ff), res_pay_ff, res_key_ff,
                          res_used_ff, res_slot_ff};
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      slot_ff       <= slot_in;
      pos_ff        <= pos_in;
      hole_ff       <= hole_in;
      hole_found_ff <= hole_found_in;
      le_ff         <= le_in;
      le_act_ff     <= le_act_in;
      dec_ff        <= dec_in;
      src_ff        <= src_in;
      rd_idx_ff     <= rd_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_used_ff   <= res_used_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   `SSP_ASSERT_HOLDS(a_count_match, clock, reset, int'(count_ff) == $countones(used_ff), "entry count out of step with used bitmap")
   `SSP_ASSERT_IMPL(a_full_count, clock, reset, rsp_load && (res_status_ff == STATUS_FULL), int'(count_ff) == SLOTS, "page full reported with free slots")
   `SSP_ASSERT_IMPL(a_move_range, clock, reset, state_ff == S_MOVE_WR, !pos_ff[PW-1] && (pos_ff < SLOTS_P) && (int'(src_ff) < SLOTS), "entry move outside the page")
   `SSP_ASSERT_NEXT(a_place_used, clock, reset, state_ff == S_PLACE, used_ff[$past(pos_idx)], "placed slot not marked used")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted slot page table: testbench
// Drives insert, delete, read, next/previous scans and unknown commands as
// request beats with random gaps and response stalls. A page model inside
// the bench tracks the used map, keys and payloads, predicts every response
// beat and checks it field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
   import ssp_pkg::*;

   localparam int SLOTS        = 64;
   localparam int KEY_BITS     = 32;
   localparam int PAYLOAD_BITS = 32;
   localparam int REQ_W = ((KEY_BITS + PAYLOAD_BITS + SLOT_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((SLOT_BITS + 1 + KEY_BITS + PAYLOAD_BITS + COUNT_BITS + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 1300;
   localparam int DRAIN_CYCLES = 4 * SLOTS + 16;
   localparam int LIMIT_CYCLES = 2000000;

   localparam logic [CMD_BITS-1:0] CMD_SPARE5 = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_SPARE7 = 3'd7;

   typedef struct {
      logic [CMD_BITS-1:0]        cmd;
      logic signed [KEY_BITS-1:0] key;
      logic [PAYLOAD_BITS-1:0]    payload;
      logic signed [SLOT_BITS-1:0] slot;
   } page_req_type;

   typedef struct {
      logic [STATUS_BITS-1:0]     status;
      logic [SLOT_BITS-1:0]       rslot;
      logic                       used;
      logic [KEY_BITS-1:0]        key;
      logic [PAYLOAD_BITS-1:0]    payload;
      logic [COUNT_BITS-1:0]      count;
   } page_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic [CMD_BITS-1:0]    req_tuser  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_W-1:0]       rsp_tdata;
   logic [STATUS_BITS-1:0] rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   page_req_type req_pending_q[$];
   page_rsp_type rsp_expect_q[$];

   bit                       page_used [SLOTS];
   bit signed [KEY_BITS-1:0] page_key  [SLOTS];
   bit [PAYLOAD_BITS-1:0]    page_pay  [SLOTS];

   int issued_cnt   = 0;
   int accepted_cnt = 0;
   int rsp_beats    = 0;
   int rsp_seen     = 0;
   int req_wait     = 0;
   int rsp_wait     = 0;
   bit req_burst    = 1'b0;
   bit rsp_burst    = 1'b0;
   int error_count  = 0;
   int cycle_count  = 0;
   int total_items  = 0;
   int cmd_hits [8];
   int full_hits    = 0;
   int shift_hits   = 0;

   sorted_slot_page_table_top #(
      .SLOTS(SLOTS),
      .KEY_BITS(KEY_BITS),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   always #10 clock = ~clock;

   function automatic void page_move(input int from, input int to);
      if (!page_used[to] && page_used[from]) begin
         page_used[to]   = 1'b1;
         page_key[to]    = page_key[from];
         page_pay[to]    = page_pay[from];
         page_used[from] = 1'b0;
      end
   endfunction

   function automatic page_rsp_type page_apply(input logic [CMD_BITS-1:0] cmd,
                                               input logic signed [KEY_BITS-1:0] k,
                                               input logic [PAYLOAD_BITS-1:0] p,
                                               input logic signed [SLOT_BITS-1:0] s);
      page_rsp_type r;
      int hole, le, good, i, idx, sl, n;
      bit stop;
      r.status  = STATUS_OK;
      r.rslot   = SLOT_NONE;
      r.used    = 1'b0;
      r.key     = '0;
      r.payload = '0;
      sl = s;
      case (cmd)
         CMD_INSERT: begin
            hole = -1;
            for (i = 0; i < SLOTS && hole < 0; i++)
               if (!page_used[i]) hole = i;
            if (hole < 0) begin
               r.status = STATUS_FULL;
               full_hits++;
            end else begin
               le = -1;
               stop = 1'b0;
               for (i = 0; i < SLOTS && !stop; i++) begin
                  if (page_used[i]) begin
                     if (page_key[i] > k) stop = 1'b1;
                     else le = i;
                  end
               end
               if (hole < le) begin
                  for (i = hole; i < le; i++) page_move(i + 1, i);
                  good = le;
               end else begin
                  for (i = hole; i > le + 1; i--) page_move(i - 1, i);
                  good = le + 1;
               end
               if (good != hole) shift_hits++;
               page_used[good] = 1'b1;
               page_key[good]  = k;
               page_pay[good]  = p;
               r.rslot   = good[SLOT_BITS-1:0];
               r.used    = 1'b1;
               r.key     = k;
               r.payload = p;
            end
         end
         CMD_DELETE, CMD_READ: begin
            r.rslot = s;
            if (sl < 0 || sl >= SLOTS) begin
               r.status = STATUS_RANGE;
            end else if (!page_used[sl]) begin
               r.status = STATUS_EMPTY;
            end else if (cmd == CMD_DELETE) begin
               page_used[sl] = 1'b0;
            end else begin
               r.used    = 1'b1;
               r.key     = page_key[sl];
               r.payload = page_pay[sl];
            end
         end
         CMD_NEXT: begin
            idx = (sl < -1) ? 0 : sl + 1;
            while (idx < SLOTS && !page_used[idx]) idx++;
            if (idx > SLOTS) idx = SLOTS;
            r.rslot = idx[SLOT_BITS-1:0];
            if (idx < SLOTS) begin
               r.used    = 1'b1;
               r.key     = page_key[idx];
               r.payload = page_pay[idx];
            end
         end
         CMD_PREV: begin
            idx = ((sl > SLOTS) ? SLOTS : sl) - 1;
            while (idx >= 0 && !page_used[idx]) idx--;
            if (idx < -1) idx = -1;
            r.rslot = idx[SLOT_BITS-1:0];
            if (idx >= 0) begin
               r.used    = 1'b1;
               r.key     = page_key[idx];
               r.payload = page_pay[idx];
            end
         end
         default: ;
      endcase
      n = 0;
      for (i = 0; i < SLOTS; i++)
         if (page_used[i]) n++;
      r.count = n[COUNT_BITS-1:0];
      return r;
   endfunction

   function automatic void push_req(input logic [CMD_BITS-1:0] cmd,
                                    input logic signed [KEY_BITS-1:0] k,
                                    input logic [PAYLOAD_BITS-1:0] p,
                                    input logic signed [SLOT_BITS-1:0] s);
      page_req_type it;
      it.cmd     = cmd;
      it.key     = k;
      it.payload = p;
      it.slot    = s;
      req_pending_q.push_back(it);
      total_items++;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want, got);
         error_count++;
      end
   endtask

   // request driver: hold the beat until taken, then wait out the drawn gap
   always @(negedge clock) begin : req_drive
      page_req_type it;
      logic [REQ_W-1:0] beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && accepted_cnt != issued_cnt)) begin
         if (req_wait > 0) begin
            req_tvalid <= 1'b0;
            req_wait <= req_wait - 1;
         end else if (req_pending_q.size() > 0) begin
            it = req_pending_q.pop_front();
            beat = '0;
            beat[KEY_BITS-1:0] = it.key;
            beat[KEY_BITS +: PAYLOAD_BITS] = it.payload;
            beat[KEY_BITS+PAYLOAD_BITS +: SLOT_BITS] = it.slot;
            req_tdata  <= beat;
            req_tuser  <= it.cmd;
            req_tvalid <= 1'b1;
            issued_cnt <= issued_cnt + 1;
            if ($urandom_range(0, 30) == 0) req_burst <= !req_burst;
            req_wait <= req_burst ? 0 : $urandom_range(0, 18);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response side: after each beat, hold ready low for a drawn stall that may be zero
   always @(negedge clock) begin : rsp_drive
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_beats != rsp_seen) begin
         rsp_seen <= rsp_beats;
         if ($urandom_range(0, 30) == 0) rsp_burst <= !rsp_burst;
         w = rsp_burst ? 0 : $urandom_range(0, 18);
         if (w == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rsp_wait <= w;
         end
      end else if (!rsp_tready) begin
         if (rsp_wait <= 1) rsp_tready <= 1'b1;
         else rsp_wait <= rsp_wait - 1;
      end
   end

   always @(posedge clock) begin : monitor
      page_rsp_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats <= rsp_beats + 1;
            got.rslot   = rsp_tdata[7:0];
            got.used    = rsp_tdata[8];
            got.key     = rsp_tdata[40:9];
            got.payload = rsp_tdata[72:41];
            got.count   = rsp_tdata[79:73];
            got.status  = rsp_tuser;
            if (rsp_expect_q.size() == 0) begin
               $display("%0t ns: response beat with nothing expected, expected none, actual 0x%0h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               want = rsp_expect_q.pop_front();
               check_field("status", want.status, got.status);
               check_field("result_slot", want.rslot, got.rslot);
               check_field("slot_used", want.used, got.used);
               check_field("out_key", want.key, got.key);
               check_field("out_payload", want.payload, got.payload);
               check_field("entry_count", want.count, got.count);
            end
         end
         if (req_tvalid && req_tready) begin
            accepted_cnt <= accepted_cnt + 1;
            cmd_hits[req_tuser]++;
            rsp_expect_q.push_back(page_apply(req_tuser, req_tdata[31:0],
                                              req_tdata[63:32], req_tdata[71:64]));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, rsp_expect_q.size());
         $display("FAIL sorted_slot_page_table_top");
         $finish;
      end
   end

   initial begin : stimulus
      int n, j, phase, plen, keymode, roll, pick;
      logic [CMD_BITS-1:0] cmd;
      logic signed [KEY_BITS-1:0] k;
      logic signed [SLOT_BITS-1:0] s;

      // empty page, extreme keys, duplicates, range, saturation and unknown-command cases
      push_req(CMD_READ,   0, 0, 0);
      push_req(CMD_DELETE, 0, 0, 5);
      push_req(CMD_NEXT,   0, 0, -1);
      push_req(CMD_PREV,   0, 0, 64);
      push_req(CMD_INSERT, 32'h7FFFFFFF, 32'hFFFFFFFF, 0);
      push_req(CMD_INSERT, 32'h80000000, 32'h00000000, 0);
      push_req(CMD_INSERT, 0, 32'h1, 0);
      push_req(CMD_INSERT, 0, 32'h2, 0);
      push_req(CMD_INSERT, -1, 32'hA5A5A5A5, 0);
      push_req(CMD_READ,   0, 0, 0);
      push_req(CMD_READ,   0, 0, 2);
      push_req(CMD_READ,   0, 0, -1);
      push_req(CMD_READ,   0, 0, 64);
      push_req(CMD_DELETE, 0, 0, 64);
      push_req(CMD_NEXT,   0, 0, 0);
      push_req(CMD_PREV,   0, 0, 4);
      push_req(CMD_NEXT,   0, 0, -128);
      push_req(CMD_PREV,   0, 0, 127);
      push_req(CMD_DELETE, 0, 0, 1);
      push_req(CMD_INSERT, 5, 32'h5A5A5A5A, 0);
      push_req(CMD_READ,   0, 0, 63);
      push_req(CMD_SPARE5, 32'hFFFFFFFF, 32'hFFFFFFFF, -1);
      push_req(CMD_SPARE6, 0, 0, 0);
      push_req(CMD_SPARE7, 0, 0, 64);
      push_req(CMD_DELETE, 0, 0, -1);

      // fill, drain and mixed phases with random content
      n = 0;
      while (n < RANDOM_ITEMS) begin
         phase   = $urandom_range(0, 2);
         plen    = $urandom_range(50, 120);
         keymode = $urandom_range(0, 2);
         for (j = 0; j < plen && n < RANDOM_ITEMS; j++) begin
            roll = $urandom_range(0, 99);
            case (phase)
               0: cmd = roll < 80 ? CMD_INSERT : roll < 85 ? CMD_DELETE :
                        roll < 92 ? CMD_READ : roll < 96 ? CMD_NEXT : CMD_PREV;
               1: cmd = roll < 15 ? CMD_INSERT : roll < 70 ? CMD_DELETE :
                        roll < 82 ? CMD_READ : roll < 91 ? CMD_NEXT : CMD_PREV;
               default: cmd = roll < 35 ? CMD_INSERT : roll < 65 ? CMD_DELETE :
                        roll < 80 ? CMD_READ : roll < 90 ? CMD_NEXT : CMD_PREV;
            endcase
            if ($urandom_range(0, 99) == 0) begin
               pick = $urandom_range(0, 2);
               cmd = pick == 0 ? CMD_SPARE5 : pick == 1 ? CMD_SPARE6 : CMD_SPARE7;
            end else begin
               n++;
            end
            case (keymode)
               0: k = $urandom_range(0, 15) - 8;
               1: k = $urandom;
               default: begin
                  pick = $urandom_range(0, 5);
                  k = pick == 0 ? 32'h80000000 : pick == 1 ? 32'h7FFFFFFF :
                      pick == 2 ? 32'h0 : pick == 3 ? -1 :
                      pick == 4 ? $urandom_range(0, 15) - 8 : $urandom;
               end
            endcase
            if (cmd == CMD_NEXT || cmd == CMD_PREV) begin
               s = SLOT_BITS'($urandom_range(0, 65) - 1);
            end else begin
               pick = $urandom_range(0, 19);
               s = SLOT_BITS'(pick == 0 ? -1 : pick == 1 ? 64 : $urandom_range(0, 63));
            end
            push_req(cmd, k, $urandom, s);
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(accepted_cnt == total_items && rsp_expect_q.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d beats: %0d insert (%0d page full, %0d with shifts), %0d delete",
               accepted_cnt, cmd_hits[CMD_INSERT], full_hits, shift_hits,
               cmd_hits[CMD_DELETE]);
      $display("  %0d read, %0d next, %0d previous, %0d unknown, %0d mismatches",
               cmd_hits[CMD_READ], cmd_hits[CMD_NEXT], cmd_hits[CMD_PREV],
               cmd_hits[CMD_SPARE5] + cmd_hits[CMD_SPARE6] + cmd_hits[CMD_SPARE7],
               error_count);
      if (error_count == 0)
         $display("PASS sorted_slot_page_table_top");
      else
         $display("FAIL sorted_slot_page_table_top");
      $finish;
   end

endmodule

// File: sorted_slot_page_table_top.f
+incdir+rtl/core
rtl/core/ssp_pkg.sv
rtl/core/ssp_ram.sv
rtl/core/ssp_alu.sv
rtl/core/sorted_slot_page_table_top.sv
tb/tb_top.sv
